/* rtl/core/sbct_pkg.sv */
// Shared constants for the segment versus box clip test.
// No dependencies; imported by sbct_ratio, segment_box_clip_test and tb.
`timescale 1ns / 1ps
`default_nettype none
package sbct_pkg;
  localparam int COORD_BITS_DEF      = 16;
  localparam int RATIO_FRAC_BITS_DEF = 16;
  localparam int ENTRY_BITS          = 17;
endpackage
`default_nettype wire

/* rtl/core/segment_box_clip_test.sv */
// Top level of the segment versus axis-aligned box entry test.
// Depends on sbct_pkg and four sbct_ratio divider lanes.
//
// Usage: drive the eight box and segment words and raise start. A word is
// taken at every rising edge where start is high and busy is low; busy is
// always low, so a new word may enter on every cycle.
// Each word yields exactly one result word, shown on hit, point_written,
// entry_x and entry_y for one cycle while done is high. The receiver cannot
// hold results off, and none is needed: the pipeline never stalls.
// A word passes an input register, the divider setup stage, the four parallel
// restoring dividers, which retire one quotient bit per stage over
// RATIO_FRAC_BITS + 2 stages, a saturation stage, two slab stages, a multiply
// stage and an output stage.
// Throughput is one word per cycle.
// Synchronous reset clears the valid bits along the pipeline, so words in
// flight at reset are dropped and done stays low until new words arrive.
// Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module segment_box_clip_test import sbct_pkg::*; #(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire signed [COORD_BITS-1:0] box_left,
  input  wire signed [COORD_BITS-1:0] box_right,
  input  wire signed [COORD_BITS-1:0] box_bottom,
  input  wire signed [COORD_BITS-1:0] box_top,
  input  wire signed [COORD_BITS-1:0] start_x,
  input  wire signed [COORD_BITS-1:0] start_y,
  input  wire signed [COORD_BITS-1:0] end_x,
  input  wire signed [COORD_BITS-1:0] end_y,
  output logic                        done,
  output logic                        hit,
  output logic                        point_written,
  output logic signed [ENTRY_BITS-1:0] entry_x,
  output logic signed [ENTRY_BITS-1:0] entry_y
);
  localparam int C       = COORD_BITS;
  localparam int F       = RATIO_FRAC_BITS;
  localparam int RW      = F + 3;
  localparam int PW      = C + F + 4;
  localparam int DIV_LAT = F + 4;
  localparam int TOT_LAT = F + 9;
  localparam logic signed [RW-1:0] RONE = RW'(1) << F;

  typedef struct packed {
    logic signed [C-1:0] bl;
    logic signed [C-1:0] br;
    logic signed [C-1:0] bb;
    logic signed [C-1:0] bt;
    logic signed [C-1:0] sx;
    logic signed [C-1:0] sy;
    logic signed [C-1:0] ex;
    logic signed [C-1:0] ey;
  } side_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Input register.
  side_t in0;
  logic  v0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    in0 <= '{box_left, box_right, box_bottom, box_top, start_x, start_y, end_x, end_y};
  end

  // Slab offsets and directions feed four divider lanes.
  logic signed [C:0] dx, dy, oxl, oxr, oyb, oyt;
  assign dx  = (C+1)'(in0.ex) - (C+1)'(in0.sx);
  assign dy  = (C+1)'(in0.ey) - (C+1)'(in0.sy);
  assign oxl = (C+1)'(in0.bl) - (C+1)'(in0.sx);
  assign oxr = (C+1)'(in0.br) - (C+1)'(in0.sx);
  assign oyb = (C+1)'(in0.bb) - (C+1)'(in0.sy);
  assign oyt = (C+1)'(in0.bt) - (C+1)'(in0.sy);

  logic signed [RW-1:0] rxl, rxr, ryb, ryt;
  sbct_ratio #(.C(C), .F(F)) u_rxl (.clk(clk), .off(oxl), .dir(dx), .ratio(rxl));
  sbct_ratio #(.C(C), .F(F)) u_rxr (.clk(clk), .off(oxr), .dir(dx), .ratio(rxr));
  sbct_ratio #(.C(C), .F(F)) u_ryb (.clk(clk), .off(oyb), .dir(dy), .ratio(ryb));
  sbct_ratio #(.C(C), .F(F)) u_ryt (.clk(clk), .off(oyt), .dir(dy), .ratio(ryt));

  // Coordinates and valid bits ride alongside the dividers.
  side_t side [DIV_LAT];
  logic  sv   [DIV_LAT];
  always_ff @(posedge clk) begin
    side[0] <= in0;
    if (rst) begin
      sv[0] <= 1'b0;
    end else begin
      sv[0] <= v0;
    end
  end
  for (genvar j = 1; j < DIV_LAT; j++) begin : g_side
    always_ff @(posedge clk) begin
      side[j] <= side[j-1];
      if (rst) begin
        sv[j] <= 1'b0;
      end else begin
        sv[j] <= sv[j-1];
      end
    end
  end

  // Stage 1: x slab narrows [0, 1].
  logic signed [RW-1:0] ax, bx, lo1_next, hi1_next;
  assign ax       = (rxr < rxl) ? rxr : rxl;
  assign bx       = (rxr < rxl) ? rxl : rxr;
  assign lo1_next = (ax > 0) ? ax : '0;
  assign hi1_next = (bx < RONE) ? bx : RONE;

  side_t                s1;
  logic                 v1, ok1;
  logic signed [RW-1:0] lo1, hi1, ryb1, ryt1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= sv[DIV_LAT-1];
    end
    s1   <= side[DIV_LAT-1];
    ok1  <= !(bx < 0) && !(ax > RONE) && (lo1_next < hi1_next);
    lo1  <= lo1_next;
    hi1  <= hi1_next;
    ryb1 <= ryb;
    ryt1 <= ryt;
  end

  // Stage 2: y slab narrows further.
  logic signed [RW-1:0] ay, by, lo2_next, hi2_next;
  assign ay       = (ryt1 < ryb1) ? ryt1 : ryb1;
  assign by       = (ryt1 < ryb1) ? ryb1 : ryt1;
  assign lo2_next = (ay > lo1) ? ay : lo1;
  assign hi2_next = (by < hi1) ? by : hi1;

  side_t                s2;
  logic                 v2, ok2;
  logic signed [RW-1:0] lo2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2  <= s1;
    ok2 <= ok1 && !(by < lo1) && !(ay > hi1) && (lo2_next < hi2_next);
    lo2 <= lo2_next;
  end

  // Stage 3: scale the directions by the entry parameter.
  logic signed [C:0] dx2, dy2;
  assign dx2 = (C+1)'(s2.ex) - (C+1)'(s2.sx);
  assign dy2 = (C+1)'(s2.ey) - (C+1)'(s2.sy);

  side_t                s3;
  logic                 v3, ok3;
  logic signed [PW-1:0] prx, pry;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3  <= s2;
    ok3 <= ok2;
    prx <= PW'(dx2) * PW'(lo2);
    pry <= PW'(dy2) * PW'(lo2);
  end

  // Stage 4: truncate toward zero, add the start point, decide the hit.
  localparam logic signed [PW-1:0] RND = (PW'(1) << F) - PW'(1);
  logic signed [PW-1:0] px, py;
  logic                 at_start, end_in;
  assign px = PW'(s3.sx) + ((prx + (prx[PW-1] ? RND : PW'(0))) >>> F);
  assign py = PW'(s3.sy) + ((pry + (pry[PW-1] ? RND : PW'(0))) >>> F);
  assign at_start = (px == PW'(s3.sx)) && (py == PW'(s3.sy));
  // Screen y grows downward: the top edge has the smaller y.
  assign end_in = (s3.bl < s3.ex) && (s3.ex < s3.br) && (s3.bt < s3.ey) && (s3.ey < s3.bb);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v3;
    end
    hit           <= ok3 && (!at_start || end_in);
    point_written <= ok3;
    entry_x       <= ok3 ? px[ENTRY_BITS-1:0] : '0;
    entry_y       <= ok3 ? py[ENTRY_BITS-1:0] : '0;
  end

  a_hit_has_point: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> point_written) else $error("hit without entry point");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !point_written) |-> (entry_x == '0 && entry_y == '0))
    else $error("entry point not cleared on miss");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOT_LAT)) else $error("result without matching word");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done) else $error("result right after reset");
endmodule
`default_nettype wire

/* rtl/core/sbct_ratio.sv */
// Pipelined saturating slab ratio (off * 2^F) / dir, one quotient bit per stage.
// Depends on sbct_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none
module sbct_ratio import sbct_pkg::*; #(
  parameter int C = COORD_BITS_DEF,
  parameter int F = RATIO_FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire signed [C:0]    off,
  input  wire signed [C:0]    dir,
  output logic signed [F+2:0] ratio
);
  localparam int W  = C + F + 2;
  localparam int QW = F + 2;
  localparam logic [QW-1:0] RMAX = QW'(1) << (F + 1);

  logic [C:0] off_mag, dir_mag;
  logic       big_pre;

  assign off_mag = off[C] ? (~off + 1'b1) : off;
  assign dir_mag = dir[C] ? (~dir + 1'b1) : dir;
  // Quotient would reach four or more: it saturates anyway.
  assign big_pre = {2'b00, off_mag} >= {dir_mag, 2'b00};

  logic [W-1:0]  rem  [QW+1];
  logic [W-1:0]  den  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic          neg  [QW+1];
  logic          zero [QW+1];
  logic          opos [QW+1];
  logic          big  [QW+1];

  always_ff @(posedge clk) begin
    rem[0]  <= {{(W-C-1){1'b0}}, off_mag} << F;
    den[0]  <= {{(W-C-1){1'b0}}, dir_mag};
    quo[0]  <= '0;
    neg[0]  <= off[C] ^ dir[C];
    zero[0] <= (dir == '0);
    opos[0] <= !off[C] && (off != '0);
    big[0]  <= big_pre;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int K = QW - 1 - i;
    logic [W-1:0] sub;
    logic         take;
    assign sub  = den[i] << K;
    assign take = rem[i] >= sub;
    always_ff @(posedge clk) begin
      rem[i+1]  <= take ? (rem[i] - sub) : rem[i];
      den[i+1]  <= den[i];
      quo[i+1]  <= {quo[i][QW-2:0], take};
      neg[i+1]  <= neg[i];
      zero[i+1] <= zero[i];
      opos[i+1] <= opos[i];
      big[i+1]  <= big[i];
    end
  end

  logic [QW-1:0]     mag;
  logic signed [F+2:0] pos;
  assign mag = (big[QW] || quo[QW] > RMAX) ? RMAX : quo[QW];
  assign pos = $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (zero[QW]) begin
      ratio <= opos[QW] ? $signed({1'b0, RMAX}) : -$signed({1'b0, RMAX});
    end else begin
      ratio <= neg[QW] ? -pos : pos;
    end
  end
endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for segment_box_clip_test: slab clip of one segment
// against one box per word. Depends on sbct_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;
  import sbct_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = RATIO_FRAC_BITS_DEF;
  localparam longint RONE = longint'(1) <<< FB;
  localparam longint RMAX = 2 * RONE;
  localparam int LATENCY = FB + 9;
  localparam int N_RANDOM = 1000;
  localparam longint CYCLE_LIMIT = 200000;

  // One box and one segment, as presented on the input ports.
  typedef struct packed {
    logic signed [CB-1:0] bl, br, bb, bt, sx, sy, ex, ey;
  } clip_word_t;

  // One result word.
  typedef struct packed {
    logic                         hit;
    logic                         written;
    logic signed [ENTRY_BITS-1:0] px;
    logic signed [ENTRY_BITS-1:0] py;
  } entry_t;

  // Saturated slab ratio in fixed point; a zero direction gives +-2 by the
  // sign of the offset. SystemVerilog division truncates toward zero.
  function automatic longint slab_ratio(longint off, longint dir);
    longint r;
    if (dir == 0) return (off > 0) ? RMAX : -RMAX;
    r = (off * RONE) / dir;
    if (r > RMAX) r = RMAX;
    if (r < -RMAX) r = -RMAX;
    return r;
  endfunction

  // Narrows [lo, hi] by one axis; returns 0 when the segment misses.
  function automatic bit narrow_slab(longint bmin, longint bmax, longint s, longint e,
                                     inout longint lo, inout longint hi);
    longint a, b, t;
    a = slab_ratio(bmin - s, e - s);
    b = slab_ratio(bmax - s, e - s);
    if (b < a) begin
      t = a; a = b; b = t;
    end
    if (b < lo || a > hi) return 0;
    if (a > lo) lo = a;
    if (b < hi) hi = b;
    return lo < hi;
  endfunction

  function automatic entry_t clip_entry(clip_word_t w);
    entry_t r;
    longint lo, hi, px, py;
    r = '0;
    lo = 0;
    hi = RONE;
    if (!narrow_slab(w.bl, w.br, w.sx, w.ex, lo, hi)) return r;
    if (!narrow_slab(w.bb, w.bt, w.sy, w.ey, lo, hi)) return r;
    px = w.sx + ((longint'(w.ex) - w.sx) * lo) / RONE;
    py = w.sy + ((longint'(w.ey) - w.sy) * lo) / RONE;
    // An entry at the start itself only counts when the end lies strictly
    // inside the box (screen y grows downward, so top < bottom).
    if (px == w.sx && py == w.sy)
      r.hit = (w.bl < w.ex) && (w.ex < w.br) && (w.bt < w.ey) && (w.ey < w.bb);
    else
      r.hit = 1'b1;
    r.written = 1'b1;
    r.px = px[ENTRY_BITS-1:0];
    r.py = py[ENTRY_BITS-1:0];
    return r;
  endfunction

  // Holds the entries still owed by the block, oldest first.
  class entry_scoreboard;
    entry_t owed[$];
    int errors;
    int checked;

    function void note_word(clip_word_t w);
      owed.push_back(clip_entry(w));
    endfunction

    function void check_entry(entry_t got);
      entry_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b written=%0b x=%0d y=%0d",
                 $time, got.hit, got.written, got.px, got.py);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, e.hit, got.hit);
        errors++;
      end
      if (got.written !== e.written) begin
        $display("%0t: point_written expected %0b actual %0b", $time, e.written, got.written);
        errors++;
      end
      if (got.px !== e.px) begin
        $display("%0t: entry_x expected %0d actual %0d", $time, e.px, got.px);
        errors++;
      end
      if (got.py !== e.py) begin
        $display("%0t: entry_y expected %0d actual %0d", $time, e.py, got.py);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, hit, point_written;
  logic signed [ENTRY_BITS-1:0] entry_x, entry_y;
  clip_word_t word_in = '0;
  longint cycles = 0;
  entry_scoreboard board = new();

  segment_box_clip_test i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .box_left(word_in.bl), .box_right(word_in.br),
    .box_bottom(word_in.bb), .box_top(word_in.bt),
    .start_x(word_in.sx), .start_y(word_in.sy),
    .end_x(word_in.ex), .end_y(word_in.ey),
    .done(done), .hit(hit), .point_written(point_written),
    .entry_x(entry_x), .entry_y(entry_y)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Results are taken at the edge that ends their cycle; the watchdog lives
  // here too so that a hung block still ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done)
      board.check_entry('{hit, point_written, entry_x, entry_y});
    if (cycles > CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one word after a random gap, or none when no_gap is set, and holds
  // it until it is taken. Start stays high across back-to-back words, so it is
  // never dropped and raised within one step.
  task automatic send_word(clip_word_t w, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    word_in <= w;
    do @(posedge clk); while (busy);
    board.note_word(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [CB-1:0] any_coord();
    return CB'($urandom());
  endfunction

  // Builds a word from plain integers, in port order.
  function automatic clip_word_t coords(int bl, int br, int bb, int bt,
                                        int sx, int sy, int ex, int ey);
    clip_word_t w;
    w.bl = CB'(bl);  w.br = CB'(br);
    w.bb = CB'(bb);  w.bt = CB'(bt);
    w.sx = CB'(sx);  w.sy = CB'(sy);
    w.ex = CB'(ex);  w.ey = CB'(ey);
    return w;
  endfunction

  // Mostly small boxes with the segment near them, so both slabs pass often,
  // some larger or inverted; the rest is fully random, with extreme values.
  function automatic clip_word_t random_word();
    clip_word_t w;
    int cx, cy, hw, hh, sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      w = {any_coord(), any_coord(), any_coord(), any_coord(),
           any_coord(), any_coord(), any_coord(), any_coord()};
    end else begin
      cx = $urandom_range(0, 60000) - 30000;
      cy = $urandom_range(0, 60000) - 30000;
      hw = (sel == 9) ? $urandom_range(0, 2500) : $urandom_range(0, 60);
      hh = (sel == 9) ? $urandom_range(0, 2500) : $urandom_range(0, 60);
      w.bl = CB'(cx - hw);  w.br = CB'(cx + hw);
      w.bt = CB'(cy - hh);  w.bb = CB'(cy + hh);
      w.sx = CB'(cx + $urandom_range(0, 6 * hw + 4) - 3 * hw - 2);
      w.sy = CB'(cy + $urandom_range(0, 6 * hh + 4) - 3 * hh - 2);
      w.ex = CB'(cx + $urandom_range(0, 6 * hw + 4) - 3 * hw - 2);
      w.ey = CB'(cy + $urandom_range(0, 6 * hh + 4) - 3 * hh - 2);
      // Axis-aligned segments exercise the zero-direction rule.
      if ($urandom_range(0, 7) == 0) w.ex = w.sx;
      if ($urandom_range(0, 7) == 0) w.ey = w.sy;
      if (sel == 8) begin
        cx = w.bl; w.bl = w.br; w.br = CB'(cx);
      end
    end
    return w;
  endfunction

  localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};
  localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};

  initial begin
    clip_word_t w;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: order is bl, br, bb, bt, sx, sy, ex, ey.
    send_word(coords(-10, 10, 10, -10, -20, 0, 20, 0));       // crosses the box
    send_word(coords(-10, 10, 10, -10, 0, 0, 5, 5));          // starts inside
    send_word(coords(-10, 10, 10, -10, 0, 0, 10, 0));         // end on the edge
    send_word(coords(-10, 10, 10, -10, -20, 20, 20, 20));     // misses in y
    send_word(coords(-10, 10, 10, -10, 50, 0, 60, 0));        // misses in x
    send_word(coords(-10, 10, 10, -10, 5, -20, 5, 20));       // zero x direction
    send_word(coords(-10, 10, 10, -10, 20, 5, 20, 5));        // zero-length outside
    send_word(coords(-10, 10, 10, -10, 0, 0, 0, 0));          // zero-length inside
    send_word(coords(10, -10, -10, 10, -20, 0, 20, 0));       // inverted box
    send_word(coords(-10, 10, 10, -10, -20, -20, 20, 20));    // diagonal corner entry
    send_word('{MINC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC});
    send_word('{MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC});
    send_word('{MAXC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MAXC});
    send_word('{MINC, MINC, MINC, MINC, MAXC, MINC, MINC, MAXC});
    send_word(coords(0, 1, 1, 0, -32768, 0, 32767, 1));       // long segment
    send_word(coords(-1, 1, 1, -1, -3, -3, 3, 1), 1);
    send_word('{'1, '1, '1, '1, '1, '1, '1, '1}, 1);
    send_word('{'0, '0, '0, '0, '0, '0, '0, '0}, 1);

    // Hold off until the pipeline is empty once, then stream random words.
    drain();
    for (int i = 0; i < N_RANDOM; i++) begin
      w = random_word();
      send_word(w, (i % 200) < 40);
    end
    drain();

    $display("Checked %0d result words: directed slab edge cases and %0d random",
             board.checked, N_RANDOM);
    $display("box and segment words with random sender gaps.");
    if (board.errors == 0 && board.owed.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/sbct_pkg.sv
rtl/core/sbct_ratio.sv
rtl/core/segment_box_clip_test.sv
test/tb.sv
